[hw/rtl/boot_image_verifier_unit_assert.svh]
// assertion helpers for the boot image verifier
`ifndef BOOT_IMAGE_VERIFIER_UNIT_ASSERT_SVH
`define BOOT_IMAGE_VERIFIER_UNIT_ASSERT_SVH

// checked on every edge out of reset
`define BIV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("boot image verifier: check failed");

// checked on every edge, reset included
`define BIV_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("boot image verifier: check failed");

`endif

[hw/rtl/biv_pkg.sv]
`timescale 1ns / 1ps

package biv_pkg;

  localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
  localparam logic [31:0] AllOnes     = 32'hFFFF_FFFF;
  localparam logic [31:0] MinSize     = 32'd8;
  localparam logic [31:0] SramBaseRst = 32'h2000_0000;
  localparam logic [31:0] SramEndRst  = 32'h2002_0000;
  localparam int unsigned CfgIdxW     = 3;

  localparam logic FUNC_HEADER = 1'b0;
  localparam logic FUNC_DATA   = 1'b1;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_BAD_MANIF = 2'd1,
    ST_BAD_VECT  = 2'd2,
    ST_BAD_CRC   = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAGIC     = 3'd0,
    CFG_VERSION   = 3'd1,
    CFG_APP_BASE  = 3'd2,
    CFG_APP_END   = 3'd3,
    CFG_SRAM_BASE = 3'd4,
    CFG_SRAM_END  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] expected_magic;
    logic [31:0] expected_version;
    logic [31:0] app_base;
    logic [31:0] app_end;
    logic [31:0] sram_base;
    logic [31:0] sram_end;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [31:0] magic;
    logic [31:0] manif_version;
    logic [31:0] load_addr;
    logic [31:0] image_len;
    logic [31:0] image_crc;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] computed_crc;
  } result_t;

  // reflected crc-32, one byte, bits unrolled
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

[hw/rtl/biv_cfg_regs.sv]
`timescale 1ns / 1ps

module biv_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [biv_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_wdata_i,
  output biv_pkg::cfg_t               cfg_o
);
  import biv_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAGIC:     cfg_d.expected_magic   = cfg_wdata_i;
        CFG_VERSION:   cfg_d.expected_version = cfg_wdata_i;
        CFG_APP_BASE:  cfg_d.app_base         = cfg_wdata_i;
        CFG_APP_END:   cfg_d.app_end          = cfg_wdata_i;
        CFG_SRAM_BASE: cfg_d.sram_base        = cfg_wdata_i;
        CFG_SRAM_END:  cfg_d.sram_end         = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_magic   <= '0;
      cfg_q.expected_version <= '0;
      cfg_q.app_base         <= '0;
      cfg_q.app_end          <= '0;
      cfg_q.sram_base        <= SramBaseRst;
      cfg_q.sram_end         <= SramEndRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/biv_check_core.sv]
`timescale 1ns / 1ps

module biv_check_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  biv_pkg::item_t    item_i,
  input  biv_pkg::cfg_t     cfg_i,
  output logic              res_valid_o,
  output biv_pkg::result_t  res_o
);
  import biv_pkg::*;

  logic            active_q, active_d;
  logic [31:0]     crc_q, crc_d;
  logic [31:0]     remain_q, remain_d;
  logic [3:0]      idx_q, idx_d;
  logic [31:0]     exp_crc_q, exp_crc_d;
  logic [31:0]     size_q, size_d;
  logic [3:0][7:0] stack_q, stack_d;
  logic [3:0][7:0] rvec_q, rvec_d;

  logic [31:0] max_size, crc_nx, final_crc, target, img_end;
  logic        manif_bad, vec_ok;

  always_comb begin
    active_d  = active_q;
    crc_d     = crc_q;
    remain_d  = remain_q;
    idx_d     = idx_q;
    exp_crc_d = exp_crc_q;
    size_d    = size_q;
    stack_d   = stack_q;
    rvec_d    = rvec_q;
    res_valid_o = 1'b0;
    res_o.status       = ST_VALID;
    res_o.computed_crc = '0;

    max_size  = cfg_i.app_end - cfg_i.app_base;
    img_end   = cfg_i.app_base + size_q;
    manif_bad = (item_i.magic != cfg_i.expected_magic)
             || (item_i.manif_version != cfg_i.expected_version)
             || (item_i.load_addr != cfg_i.app_base)
             || (item_i.image_len < MinSize)
             || (item_i.image_len > max_size);

    crc_nx    = crc_byte(crc_q, item_i.data_byte);
    final_crc = ~crc_nx;
    target    = '0;
    vec_ok    = 1'b0;

    if (item_valid_i) begin
      if (item_i.func == FUNC_HEADER) begin
        crc_d   = AllOnes;
        idx_d   = '0;
        stack_d = '0;
        rvec_d  = '0;
        if (manif_bad) begin
          active_d           = 1'b0;
          res_valid_o        = 1'b1;
          res_o.status       = ST_BAD_MANIF;
        end else begin
          active_d  = 1'b1;
          remain_d  = item_i.image_len;
          exp_crc_d = item_i.image_crc;
          size_d    = item_i.image_len;
        end
      end else if (active_q) begin
        crc_d    = crc_nx;
        remain_d = remain_q - 32'd1;
        // first eight bytes form the stack pointer and reset vector
        if (idx_q < 4'd4) begin
          stack_d[idx_q[1:0]] = item_i.data_byte;
        end else if (idx_q < 4'd8) begin
          rvec_d[idx_q[1:0]] = item_i.data_byte;
        end
        if (idx_q < 4'd8) begin
          idx_d = idx_q + 4'd1;
        end
        if (remain_q == 32'd1) begin
          target = {rvec_d[3:1], rvec_d[0][7:1], 1'b0};
          vec_ok = (stack_d > cfg_i.sram_base) && (stack_d <= cfg_i.sram_end)
                && (stack_d[0][1:0] == 2'b00) && rvec_d[0][0]
                && (target >= cfg_i.app_base) && (target < img_end);
          active_d           = 1'b0;
          res_valid_o        = 1'b1;
          res_o.computed_crc = final_crc;
          priority if (!vec_ok) begin
            res_o.status = ST_BAD_VECT;
          end else if (final_crc != exp_crc_q) begin
            res_o.status = ST_BAD_CRC;
          end else begin
            res_o.status = ST_VALID;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q     <= crc_d;
    remain_q  <= remain_d;
    exp_crc_q <= exp_crc_d;
    size_q    <= size_d;
    stack_q   <= stack_d;
    rvec_q    <= rvec_d;
  end

endmodule

[hw/rtl/boot_image_verifier_unit.sv]
`timescale 1ns / 1ps

// Boot image verifier. A header word (func 0) carries the manifest; it is
// checked against the configured magic, version, application base and a size
// of 8 up to (app_end - app_base), and a failing header gives a bad-manifest
// result at once. A good header opens a check; each data word (func 1) then
// feeds one image byte into a reflected CRC-32, the first eight bytes also
// forming the stack pointer and reset vector, and after the last byte one
// result word gives the status (bad vector table, then bad CRC, then valid)
// and the computed CRC. Data words outside a check and a good header give no
// result. One word is taken every cycle while the output is not stalled; a
// result passes from the input register through the byte-wide CRC update
// into the result register. The user must write configuration only while no
// word is in flight; the block itself does not enforce this.

module boot_image_verifier_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [31:0]                 magic_i,
  input  logic [31:0]                 manif_version_i,
  input  logic [31:0]                 load_addr_i,
  input  logic [31:0]                 image_len_i,
  input  logic [31:0]                 image_crc_i,
  input  logic [7:0]                  data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [31:0]                 computed_crc_o,
  input  logic                        cfg_we_i,
  input  logic [biv_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_wdata_i
);
  import biv_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  logic    advance, load;
  logic    res_valid;
  result_t res;
  logic    out_valid_q;
  result_t out_q;

  biv_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // the input register moves on whenever the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.func          <= func_i;
      item_q.magic         <= magic_i;
      item_q.manif_version <= manif_version_i;
      item_q.load_addr     <= load_addr_i;
      item_q.image_len     <= image_len_i;
      item_q.image_crc     <= image_crc_i;
      item_q.data_byte     <= data_byte_i;
    end
  end

  biv_check_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (advance),
    .item_i       (item_q),
    .cfg_i        (cfg),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign computed_crc_o = out_q.computed_crc;

`include "boot_image_verifier_unit_assert.svh"

  `BIV_ASSERT_ALWAYS(a_manif_crc, out_valid_o && status_o == ST_BAD_MANIF |-> computed_crc_o == '0)
  `BIV_ASSERT(a_stall_when_blocked, in_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
  `BIV_ASSERT(a_result_from_advance, $rose(out_valid_o) |-> $past(advance))

endmodule
